// ===== rtl/core/strict_decimal_amount_parser_assert.svh =====
// Assertion helpers for the amount parser checks.
`ifndef STRICT_DECIMAL_AMOUNT_PARSER_ASSERT_SVH
`define STRICT_DECIMAL_AMOUNT_PARSER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SDAP_ASSERT_IMPLY(NAME, CLK, RSTN, ANTE, CONS) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("sdap: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define SDAP_ASSERT_NEXT(NAME, CLK, RSTN, ANTE, CONS) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("sdap: next-cycle check failed");

`endif

// ===== rtl/core/sdap_pkg.sv =====
package sdap_pkg;

    localparam int CHAR_W   = 8;
    localparam int AMOUNT_W = 63;
    localparam int INT_W    = 40;
    localparam int FRAC_W   = 27;
    localparam int COUNT_W  = 4;
    localparam int WEIGHT_W = 24;
    localparam int DIGIT_W  = 4;
    localparam int SUM_W    = AMOUNT_W + 1;

    // Table places: eight weighted digits, then one of weight zero
    localparam int FRAC_PLACES = 9;

    localparam logic [INT_W-1:0]  INT_LIMIT  = 40'd92233720368;
    localparam logic [FRAC_W-1:0] UNIT_SCALE = 27'd100000000;

    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

    function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [COUNT_W-1:0] place);
        logic [WEIGHT_W-1:0] w;
        case (place)
            4'd0:    w = 24'd10000000;
            4'd1:    w = 24'd1000000;
            4'd2:    w = 24'd100000;
            4'd3:    w = 24'd10000;
            4'd4:    w = 24'd1000;
            4'd5:    w = 24'd100;
            4'd6:    w = 24'd10;
            4'd7:    w = 24'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/sdap_if.sv =====
interface sdap_char_if;
    logic                           valid;
    logic                           ready;
    logic [sdap_pkg::CHAR_W-1:0]    char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface sdap_result_if;
    logic                           valid;
    logic                           ready;
    logic                           is_valid;
    logic [sdap_pkg::AMOUNT_W-1:0]  amount;

    modport source (output valid, output is_valid, output amount, input ready);
    modport sink   (input valid, input is_valid, input amount, output ready);
endinterface

// ===== rtl/core/strict_decimal_amount_parser.sv =====
// Strict decimal amount parser. Takes one string byte per beat on chars; a zero
// byte closes the string and yields one beat on results: is_valid and the amount
// in units of 1e-8 (zero when invalid). Digits before an optional single dot form
// the integer part (rejected above 92233720368), up to MAX_FRAC_DIGITS digits
// (nine at most) after it form the fraction; any other byte, a second dot, an
// extra fraction digit, an empty string or a lone dot gives an invalid result.
// Input runs at one byte per clock, and the result appears on results in the
// cycle after its zero byte is taken; the single output register is the only
// thing that stalls input, then only while a result is held by results.ready low.
module strict_decimal_amount_parser #(
    parameter int MAX_FRAC_DIGITS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    sdap_char_if.sink       chars,
    sdap_result_if.source   results
);

    localparam logic [sdap_pkg::COUNT_W-1:0] FRAC_LIMIT =
        sdap_pkg::COUNT_W'(MAX_FRAC_DIGITS);
    localparam logic [sdap_pkg::COUNT_W-1:0] FRAC_TABLE_END =
        sdap_pkg::COUNT_W'(sdap_pkg::FRAC_PLACES);

    logic [sdap_pkg::INT_W-1:0]    int_accum_reg,  int_accum_next;
    logic [sdap_pkg::AMOUNT_W-1:0] scaled_reg,     scaled_next;
    logic [sdap_pkg::FRAC_W-1:0]   frac_accum_reg, frac_accum_next;
    logic [sdap_pkg::COUNT_W-1:0]  frac_count_reg, frac_count_next;
    logic saw_int_digit_reg, saw_int_digit_next;
    logic in_fraction_reg,   in_fraction_next;
    logic failed_reg,        failed_next;

    logic                          out_valid_reg,    out_valid_next;
    logic                          out_is_valid_reg, out_is_valid_next;
    logic [sdap_pkg::AMOUNT_W-1:0] out_amount_reg,   out_amount_next;

    logic                          accept;
    logic                          is_nul, is_digit, is_dot;
    logic [sdap_pkg::DIGIT_W-1:0]  digit;
    logic [sdap_pkg::INT_W:0]      int_new;
    logic [sdap_pkg::SUM_W-1:0]    scaled_new;
    logic [sdap_pkg::SUM_W-1:0]    digit_scaled;
    logic                          frac_room;
    logic [sdap_pkg::FRAC_W:0]     frac_term;
    logic [sdap_pkg::SUM_W-1:0]    sum;
    logic                          ok;

    assign chars.ready      = !out_valid_reg || results.ready;
    assign accept           = chars.valid && chars.ready;
    assign results.valid    = out_valid_reg;
    assign results.is_valid = out_is_valid_reg;
    assign results.amount   = out_amount_reg;

    always_comb
    begin
        is_nul   = (chars.char_byte == sdap_pkg::CHAR_NUL);
        is_dot   = (chars.char_byte == sdap_pkg::CHAR_DOT);
        is_digit = (chars.char_byte >= sdap_pkg::CHAR_ZERO) &&
                   (chars.char_byte <= sdap_pkg::CHAR_NINE);
        // ASCII digits 0x30..0x39: the low nibble is the value
        digit    = chars.char_byte[sdap_pkg::DIGIT_W-1:0];

        // x*10 + d as shift-add; never exceeds 40 bits while not failed
        int_new = ({1'b0, int_accum_reg} << 3) + ({1'b0, int_accum_reg} << 1)
                + (sdap_pkg::INT_W+1)'(digit);

        // Integer part kept pre-scaled by 1e8 alongside, valid while within limit
        digit_scaled = sdap_pkg::SUM_W'(digit) * sdap_pkg::SUM_W'(sdap_pkg::UNIT_SCALE);
        scaled_new   = ({1'b0, scaled_reg} << 3) + ({1'b0, scaled_reg} << 1) + digit_scaled;

        frac_room = (frac_count_reg < FRAC_LIMIT) && (frac_count_reg < FRAC_TABLE_END);
        frac_term = (sdap_pkg::FRAC_W+1)'(digit)
                  * (sdap_pkg::FRAC_W+1)'(sdap_pkg::frac_weight(frac_count_reg));

        ok  = !failed_reg && (saw_int_digit_reg || (frac_count_reg != '0));
        sum = {1'b0, scaled_reg} + sdap_pkg::SUM_W'(frac_accum_reg);
        // top bit set means above the signed 64-bit maximum
        if (sum[sdap_pkg::SUM_W-1])
        begin
            ok = 1'b0;
        end
    end

    always_comb
    begin
        int_accum_next     = int_accum_reg;
        scaled_next        = scaled_reg;
        frac_accum_next    = frac_accum_reg;
        frac_count_next    = frac_count_reg;
        saw_int_digit_next = saw_int_digit_reg;
        in_fraction_next   = in_fraction_reg;
        failed_next        = failed_reg;
        out_valid_next     = out_valid_reg && !results.ready;
        out_is_valid_next  = out_is_valid_reg;
        out_amount_next    = out_amount_reg;

        if (accept)
        begin
            if (is_nul)
            begin
                out_valid_next     = 1'b1;
                out_is_valid_next  = ok;
                out_amount_next    = ok ? sum[sdap_pkg::AMOUNT_W-1:0] : '0;
                int_accum_next     = '0;
                scaled_next        = '0;
                frac_accum_next    = '0;
                frac_count_next    = '0;
                saw_int_digit_next = 1'b0;
                in_fraction_next   = 1'b0;
                failed_next        = 1'b0;
            end
            else if (!failed_reg)
            begin
                if (is_digit)
                begin
                    if (!in_fraction_reg)
                    begin
                        int_accum_next     = int_new[sdap_pkg::INT_W-1:0];
                        scaled_next        = scaled_new[sdap_pkg::AMOUNT_W-1:0];
                        saw_int_digit_next = 1'b1;
                        if (int_new > {1'b0, sdap_pkg::INT_LIMIT})
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else if (!frac_room)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        frac_accum_next = frac_accum_reg + frac_term[sdap_pkg::FRAC_W-1:0];
                        frac_count_next = frac_count_reg + 1'b1;
                    end
                end
                else if (is_dot)
                begin
                    if (in_fraction_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        in_fraction_next = 1'b1;
                    end
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_accum_reg     <= '0;
            scaled_reg        <= '0;
            frac_accum_reg    <= '0;
            frac_count_reg    <= '0;
            saw_int_digit_reg <= 1'b0;
            in_fraction_reg   <= 1'b0;
            failed_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            int_accum_reg     <= int_accum_next;
            scaled_reg        <= scaled_next;
            frac_accum_reg    <= frac_accum_next;
            frac_count_reg    <= frac_count_next;
            saw_int_digit_reg <= saw_int_digit_next;
            in_fraction_reg   <= in_fraction_next;
            failed_reg        <= failed_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_is_valid_reg <= out_is_valid_next;
        out_amount_reg   <= out_amount_next;
    end

endmodule

// ===== rtl/core/sdap_checker.sv =====
`include "strict_decimal_amount_parser_assert.svh"

module sdap_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [sdap_pkg::CHAR_W-1:0]   in_byte,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          out_is_valid,
    input logic [sdap_pkg::AMOUNT_W-1:0] out_amount
);

    // A terminating byte always produces a result beat on the next cycle
    `SDAP_ASSERT_NEXT(a_nul_gives_result, clk, rst_n, in_valid && in_ready && in_byte == sdap_pkg::CHAR_NUL, out_valid)

    `SDAP_ASSERT_IMPLY(a_invalid_amount_zero, clk, rst_n, out_valid && !out_is_valid, out_amount == '0)

    // Single output register: a held result must block new bytes
    `SDAP_ASSERT_IMPLY(a_stall_blocks_input, clk, rst_n, out_valid && !out_ready, !in_ready)

    `SDAP_ASSERT_NEXT(a_stall_holds_beat, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_is_valid) && $stable(out_amount))

endmodule

bind strict_decimal_amount_parser sdap_checker u_sdap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (chars.valid),
    .in_ready     (chars.ready),
    .in_byte      (chars.char_byte),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_is_valid (results.is_valid),
    .out_amount   (results.amount)
);

// ===== test/strict_decimal_amount_parser_tb.sv =====
module strict_decimal_amount_parser_tb;

    localparam int FRAC_DIGITS  = 8;
    localparam int RANDOM_BYTES = 1200;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct packed {
        logic                          is_valid;
        logic [sdap_pkg::AMOUNT_W-1:0] amount;
    } amount_t;

    typedef logic [sdap_pkg::CHAR_W-1:0] char_q_t[$];

    logic clk;
    logic rst_n;

    sdap_char_if   chars();
    sdap_result_if results();

    strict_decimal_amount_parser #(.MAX_FRAC_DIGITS(FRAC_DIGITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results)
    );

    // predictor state
    logic [sdap_pkg::INT_W-1:0]   int_part;
    logic [sdap_pkg::FRAC_W-1:0]  frac_part;
    logic [sdap_pkg::COUNT_W-1:0] frac_places;
    logic                         saw_digit;
    logic                         past_dot;
    logic                         rejected;

    amount_t pending_amounts[$];
    int      errors;
    int      live_bytes;
    bit      idle_on;
    int      quiet_cycles;
    int      ready_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [sdap_pkg::FRAC_W-1:0] place_weight(
        input logic [sdap_pkg::COUNT_W-1:0] place);
        logic [sdap_pkg::FRAC_W-1:0] w;
        w = 1;
        if (place >= 8)
            return '0;
        repeat (7 - place)
            w = w * 10;
        return w;
    endfunction

    function automatic logic [sdap_pkg::CHAR_W-1:0] rand_digit();
        return sdap_pkg::CHAR_ZERO + sdap_pkg::CHAR_W'($urandom_range(0, 9));
    endfunction

    task automatic clear_amount();
        int_part    = '0;
        frac_part   = '0;
        frac_places = '0;
        saw_digit   = 1'b0;
        past_dot    = 1'b0;
        rejected    = 1'b0;
    endtask

    task automatic predict_byte(input logic [sdap_pkg::CHAR_W-1:0] b);
        logic [sdap_pkg::SUM_W-1:0] total;
        logic                       ok;
        amount_t                    res;
        if (b == sdap_pkg::CHAR_NUL) begin
            ok    = !rejected && (saw_digit || frac_places != 0);
            total = '0;
            if (ok) begin
                total = sdap_pkg::SUM_W'(int_part) * sdap_pkg::SUM_W'(sdap_pkg::UNIT_SCALE)
                      + sdap_pkg::SUM_W'(frac_part);
                if (total[sdap_pkg::SUM_W-1])
                    ok = 1'b0;
            end
            res.is_valid = ok;
            res.amount   = ok ? total[sdap_pkg::AMOUNT_W-1:0] : '0;
            pending_amounts.push_back(res);
            clear_amount();
        end else if (!rejected) begin
            if (b >= sdap_pkg::CHAR_ZERO && b <= sdap_pkg::CHAR_NINE) begin
                if (!past_dot) begin
                    int_part  = int_part * 10 + sdap_pkg::INT_W'(b[3:0]);
                    saw_digit = 1'b1;
                    if (int_part > sdap_pkg::INT_LIMIT)
                        rejected = 1'b1;
                end else if (frac_places >= FRAC_DIGITS || frac_places > 8) begin
                    rejected = 1'b1;
                end else begin
                    frac_part   = frac_part
                                + sdap_pkg::FRAC_W'(b[3:0]) * place_weight(frac_places);
                    frac_places = frac_places + 1'b1;
                end
            end else if (b == sdap_pkg::CHAR_DOT) begin
                if (past_dot)
                    rejected = 1'b1;
                else
                    past_dot = 1'b1;
            end else begin
                rejected = 1'b1;
            end
        end
    endtask

    // valid is left high between beats; only a gap or a drain lowers it
    task automatic send_byte(input logic [sdap_pkg::CHAR_W-1:0] b);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            chars.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        chars.valid     <= 1'b1;
        chars.char_byte <= b;
        do
            @(posedge clk);
        while (!chars.ready);
        if (!rejected || b == sdap_pkg::CHAR_NUL)
            live_bytes++;
        predict_byte(b);
    endtask

    task automatic send_amount(input char_q_t s);
        foreach (s[i])
            send_byte(s[i]);
        send_byte(sdap_pkg::CHAR_NUL);
    endtask

    task automatic send_text(input string t);
        char_q_t s;
        for (int i = 0; i < t.len(); i++)
            s.push_back(t[i]);
        send_amount(s);
    endtask

    task automatic drain();
        chars.valid <= 1'b0;
        while (pending_amounts.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_empty_and_dot();
        send_text("");
        send_text(".");
        send_text("..");
        drain();
    endtask

    task automatic test_integer_and_fraction();
        send_text("7");
        send_text(".5");
        send_text("9.");
        drain();
    endtask

    task automatic test_bad_bytes();
        char_q_t s;
        // 0xFF mid-string, then bytes after failure are ignored
        s = '{sdap_pkg::CHAR_ZERO + 8'd1, 8'hFF, 8'h80, sdap_pkg::CHAR_DOT};
        send_amount(s);
        send_text("0.123456789");
        drain();
    endtask

    task automatic random_amount();
        char_q_t s;
        int      kind;
        int      n;
        string   tail;
        kind = $urandom_range(0, 99);
        tail = "5477580";
        if (kind < 12) begin
            // near the integer and sum limits
            s = '{"9", "2", "2", "3", "3", "7", "2", "0", "3", "6"};
            case ($urandom_range(0, 2))
                0: s.push_back(sdap_pkg::CHAR_ZERO + sdap_pkg::CHAR_W'($urandom_range(6, 9)));
                1: begin
                    s.push_back("8");
                    s.push_back(sdap_pkg::CHAR_DOT);
                    repeat (8) s.push_back(rand_digit());
                end
                default: begin
                    s.push_back("8");
                    s.push_back(sdap_pkg::CHAR_DOT);
                    for (int i = 0; i < tail.len(); i++)
                        s.push_back(tail[i]);
                    s.push_back(sdap_pkg::CHAR_ZERO + sdap_pkg::CHAR_W'($urandom_range(6, 9)));
                end
            endcase
        end else begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
            repeat (n) s.push_back(rand_digit());
            if ($urandom_range(0, 3) != 0) begin
                s.push_back(sdap_pkg::CHAR_DOT);
                n = (kind >= 80) ? $urandom_range(0, 9) : $urandom_range(0, 8);
                repeat (n) s.push_back(rand_digit());
            end
        end
        if (kind >= 80) begin
            case ($urandom_range(0, 2))
                0: s.insert($urandom_range(0, s.size()),
                            sdap_pkg::CHAR_W'($urandom_range(1, 255)));
                1: s.insert($urandom_range(0, s.size()), sdap_pkg::CHAR_DOT);
                default: repeat ($urandom_range(1, 4)) s.push_back(rand_digit());
            endcase
            repeat ($urandom_range(0, 3)) s.push_back(sdap_pkg::CHAR_W'($urandom_range(1, 255)));
        end
        send_amount(s);
    endtask

    task automatic test_random();
        int target;
        target = live_bytes + RANDOM_BYTES;
        while (live_bytes < target) begin
            if (live_bytes > target - RANDOM_BYTES / 5)
                idle_on = 1'b0;
            random_amount();
        end
        drain();
    endtask

    // result check and receiver stalls
    always @(posedge clk) begin
        amount_t want;
        if (results.valid && results.ready) begin
            if (pending_amounts.size() == 0) begin
                $error("unexpected result: is_valid=%0b amount=%0d",
                       results.is_valid, results.amount);
                errors++;
            end else begin
                want = pending_amounts.pop_front();
                if (results.is_valid !== want.is_valid) begin
                    $error("is_valid: expected %0b, got %0b", want.is_valid, results.is_valid);
                    errors++;
                end
                if (results.amount !== want.amount) begin
                    $error("amount: expected %0d, got %0d", want.amount, results.amount);
                    errors++;
                end
            end
        end
        if (rst_n) begin
            if (ready_left > 0) begin
                ready_left--;
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                results.ready <= 1'b0;
                ready_left = $urandom_range(1, 16) - 1;
            end else begin
                results.ready <= 1'b1;
                ready_left = $urandom_range(1, 24) - 1;
            end
        end
    end

    always @(posedge clk) begin
        if ((chars.valid && chars.ready) || (results.valid && results.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.char_byte = '0;
        results.ready   = 1'b0;
        errors          = 0;
        live_bytes      = 0;
        quiet_cycles    = 0;
        ready_left      = 0;
        idle_on         = 1'b1;
        clear_amount();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_dot();
        test_integer_and_fraction();
        test_bad_bytes();
        test_random();

        repeat (4) @(posedge clk);
        if (errors == 0 && pending_amounts.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
